// ===== hdl/pnc_pkg.sv =====
`timescale 1ns / 1ps

package pnc_pkg;

  // Palette geometry. Entry 0 is not a colour, so entries 1 up to the last
  // usable index take part; an index is 8 bits wide, which caps that at 255.
  localparam int PALETTE_SIZE = 256;
  localparam int IDX_W        = 8;
  localparam int COLOR_W      = 8;
  localparam int LAST_USABLE  = (PALETTE_SIZE - 1 > 255) ? 255 : PALETTE_SIZE - 1;
  localparam int NUM_CELLS    = LAST_USABLE;

  // Squared distance over three channels: 3 * 255^2 fits in 18 bits.
  localparam int SQ_W   = 2 * COLOR_W;
  localparam int DIST_W = SQ_W + 2;

  localparam logic [COLOR_W-1:0] WHITE_LEVEL        = '1;
  localparam logic [IDX_W-1:0]   SEARCH_START_INDEX = IDX_W'(7);

  // Operation codes carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SEARCH = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  // One colour value.
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  // Token that walks the cell chain for a search or a read.
  typedef struct packed {
    logic              valid;
    logic              search;
    logic [IDX_W-1:0]  req_idx;
    rgb_t              query;
    logic              have;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;
    rgb_t              best_rgb;
  } tok_t;

  // Palette write broadcast to every cell.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    rgb_t             rgb;
  } wr_t;

  // Squared absolute difference of two colour components.
  function automatic logic [SQ_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                              input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

// ===== hdl/pnc_cell.sv =====
`timescale 1ns / 1ps

module pnc_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic [pnc_pkg::IDX_W-1:0] cell_idx,
  input  pnc_pkg::wr_t              wr,
  input  pnc_pkg::tok_t             tok_in,
  output pnc_pkg::tok_t             tok_out
);

  pnc_pkg::rgb_t                entry_r;
  pnc_pkg::tok_t                tok_r;
  pnc_pkg::tok_t                tok_nxt;
  logic [pnc_pkg::DIST_W-1:0]   entry_dist;

  // Palette entry held by this cell; loaded when the write index matches.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      entry_r <= wr.rgb;
    end
  end

  // Squared RGB distance between this entry and the query colour.
  assign entry_dist = pnc_pkg::DIST_W'(pnc_pkg::sq_diff(entry_r.red,   tok_in.query.red))
                    + pnc_pkg::DIST_W'(pnc_pkg::sq_diff(entry_r.green, tok_in.query.green))
                    + pnc_pkg::DIST_W'(pnc_pkg::sq_diff(entry_r.blue,  tok_in.query.blue));

  // A search takes this entry if it is the first or strictly nearer, which
  // keeps the lowest index on a tie. A read picks up the entry on a match.
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.search) begin
      if (!tok_in.have || (entry_dist < tok_in.best_dist)) begin
        tok_nxt.have      = 1'b1;
        tok_nxt.best_dist = entry_dist;
        tok_nxt.best_idx  = cell_idx;
        tok_nxt.best_rgb  = entry_r;
      end
    end else if (tok_in.req_idx == cell_idx) begin
      tok_nxt.best_rgb = entry_r;
    end
  end

  // Hand the token on to the next cell; only the valid flag is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== hdl/palette_nearest_color_top.sv =====
`timescale 1ns / 1ps

// Palette of up to 255 RGB colours (entries 1 to 255) with a nearest-colour
// search. Each entry lives in one cell of a chain; a search or read enters
// the chain as a token that moves one cell per cycle unless the output stalls,
// and its result is loaded into the output register as the token leaves the
// last cell. The next input transaction is taken only once the token has left
// the chain, so one search or read is in flight at a time; a stalled output
// holds the chain and the input for as long as it waits. A write is stored in
// its cell when accepted and gives no result; a write to entry 0 or an unused
// opcode is dropped. A read of entry 0 returns white. Entries power up
// undefined, so every entry must be written before a search, and an entry
// must be written before it is read.
module palette_nearest_color_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] entry_index, [15:8] red_in, [23:16] green_in, [31:24] blue_in
  input  logic [31:0] in_tdata,
  // [1:0] opcode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] best_index, [15:8] red_out, [23:16] green_out, [31:24] blue_out
  output logic [31:0] out_tdata
);

  localparam int LAST = pnc_pkg::NUM_CELLS - 1;

  pnc_pkg::op_t   op;
  pnc_pkg::rgb_t  in_rgb;
  pnc_pkg::wr_t   wr;
  pnc_pkg::tok_t  inject;
  pnc_pkg::tok_t  tok [pnc_pkg::NUM_CELLS];
  logic [pnc_pkg::NUM_CELLS-1:0] tok_valid_vec;
  logic           in_fire;
  logic           adv;
  logic           leave;
  logic           busy_r;
  logic           busy_nxt;
  logic           out_valid_r;
  logic           out_valid_nxt;
  logic           out_search_r;
  logic [31:0]    out_data_r;

  assign op      = pnc_pkg::op_t'(in_tuser);
  assign in_rgb  = '{red: in_tdata[15:8], green: in_tdata[23:16], blue: in_tdata[31:24]};
  assign in_fire = in_tvalid && in_tready;

  // The chain halts only while a finished token waits behind a full output.
  assign adv   = !(tok[LAST].valid && out_valid_r && !out_tready);
  assign leave = tok[LAST].valid && adv;

  // Decode the input transaction into a palette write or a chain token.
  always_comb begin
    wr                 = '0;
    wr.idx             = in_tdata[7:0];
    wr.rgb             = in_rgb;
    inject             = '0;
    inject.req_idx     = in_tdata[7:0];
    inject.query       = in_rgb;
    case (op)
      pnc_pkg::OP_WRITE: begin
        wr.en = in_fire;
      end
      pnc_pkg::OP_SEARCH: begin
        inject.valid    = in_fire;
        inject.search   = 1'b1;
        inject.best_idx = pnc_pkg::SEARCH_START_INDEX;
      end
      pnc_pkg::OP_READ: begin
        inject.valid    = in_fire;
        inject.best_idx = in_tdata[7:0];
        inject.best_rgb = '{red: pnc_pkg::WHITE_LEVEL, green: pnc_pkg::WHITE_LEVEL,
                            blue: pnc_pkg::WHITE_LEVEL};
      end
      default: begin
      end
    endcase
  end

  // Row of cells, entry k+1 in cell k.
  for (genvar k = 0; k < pnc_pkg::NUM_CELLS; k++) begin : g_cell
    pnc_pkg::tok_t tok_src;
    if (k == 0) begin : g_head
      assign tok_src = inject;
    end else begin : g_link
      assign tok_src = tok[k-1];
    end
    pnc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (pnc_pkg::IDX_W'(k + 1)),
      .wr       (wr),
      .tok_in   (tok_src),
      .tok_out  (tok[k])
    );
    assign tok_valid_vec[k] = tok[k].valid;
  end

  // One token in the chain at a time; input is closed while it travels.
  always_comb begin
    busy_nxt = busy_r;
    if (leave) begin
      busy_nxt = 1'b0;
    end else if (inject.valid) begin
      busy_nxt = 1'b1;
    end
  end

  // Output register, loaded as the token leaves the last cell.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (leave) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (leave) begin
      out_search_r <= tok[LAST].search;
      out_data_r   <= {tok[LAST].best_rgb.blue, tok[LAST].best_rgb.green,
                       tok[LAST].best_rgb.red, tok[LAST].best_idx};
    end
  end

  assign in_tready  = !busy_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // While busy exactly one token is in flight, otherwise none.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ($countones(tok_valid_vec) == 1))
    else $error("busy without exactly one token in the chain");

  a_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (tok_valid_vec == '0))
    else $error("token in the chain while idle");

  // A search or read transaction always sets busy in the next cycle.
  a_inject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    inject.valid |=> busy_r)
    else $error("token injected without busy");

  // A search result always names a usable entry.
  a_search_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_search_r) |->
      ((out_data_r[7:0] != '0) &&
       (out_data_r[7:0] <= pnc_pkg::IDX_W'(pnc_pkg::LAST_USABLE))))
    else $error("search result index out of range");

endmodule

// ===== bench/tb_palette_nearest_color_top.sv =====
`timescale 1ns / 1ps

module tb_palette_nearest_color_top;

  // Opcode that the block ignores; it has no member in op_t.
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         ITEM_TARGET = 1750;
  localparam int         HOLD_AT     = 150;
  localparam int         HOLD_CYCLES = 2500;
  localparam int         TAIL_CYCLES = 300;
  localparam int         CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]                op;
    logic [pnc_pkg::IDX_W-1:0] idx;
    pnc_pkg::rgb_t             colour;
  } palette_req_t;

  typedef struct packed {
    logic [pnc_pkg::IDX_W-1:0] idx;
    pnc_pkg::rgb_t             colour;
  } palette_answer_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  palette_req_t    palette_requests[$];
  palette_answer_t expected_colours[$];
  pnc_pkg::rgb_t   model_palette[0:pnc_pkg::PALETTE_SIZE-1];
  pnc_pkg::rgb_t   chosen_palette[0:pnc_pkg::PALETTE_SIZE-1];
  palette_req_t    offered_req;
  int              counted_items;
  int              total_items;
  int              sent_items = 0;
  int              mismatch_count;
  int              send_gap;
  int              recv_gap;
  bit              send_calm;
  bit              recv_calm;
  int              results_seen;
  logic            drain_hold;
  bit              hold_done;
  int              hold_cycles;
  int              cycle_count;

  palette_nearest_color_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length before the next transaction; calm stretches have no gaps at all.
  function automatic int next_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = ~calm;
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic pnc_pkg::rgb_t make_rgb(int r, int g, int b);
    pnc_pkg::rgb_t c;
    c.red   = pnc_pkg::COLOR_W'(r);
    c.green = pnc_pkg::COLOR_W'(g);
    c.blue  = pnc_pkg::COLOR_W'(b);
    return c;
  endfunction

  function automatic pnc_pkg::rgb_t random_rgb();
    return make_rgb($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  // Each component at either end of its range.
  function automatic pnc_pkg::rgb_t extreme_rgb();
    return make_rgb($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                    $urandom_range(0, 1) * 255);
  endfunction

  // Moves a component by a small amount, clamped to the byte range.
  function automatic logic [pnc_pkg::COLOR_W-1:0] nudge(logic [pnc_pkg::COLOR_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return pnc_pkg::COLOR_W'(v);
  endfunction

  // Queues one request and keeps the generator's own view of the palette.
  task automatic queue_request(logic [1:0] op, int idx, pnc_pkg::rgb_t colour);
    palette_req_t req;
    req.op     = op;
    req.idx    = pnc_pkg::IDX_W'(idx);
    req.colour = colour;
    palette_requests.push_back(req);
    if (op == pnc_pkg::OP_WRITE && idx >= 1 && idx <= pnc_pkg::LAST_USABLE)
      chosen_palette[idx] = colour;
    if (op != OP_UNUSED &&
        !(op == pnc_pkg::OP_WRITE && (idx < 1 || idx > pnc_pkg::LAST_USABLE)))
      counted_items++;
  endtask

  // Works out the answer to an accepted request and updates the palette copy.
  task automatic predict_palette_answer(palette_req_t req);
    palette_answer_t ans;
    int              best_dist;
    int              sq_dist;
    int              dr;
    int              dg;
    int              db;
    bit              have;
    pnc_pkg::rgb_t   e;
    if (req.op == pnc_pkg::OP_WRITE) begin
      if (req.idx >= 1 && req.idx <= pnc_pkg::LAST_USABLE) model_palette[req.idx] = req.colour;
    end else if (req.op == pnc_pkg::OP_SEARCH) begin
      // Walk the usable entries; a strictly smaller distance replaces the best.
      ans.idx   = pnc_pkg::SEARCH_START_INDEX;
      best_dist = 0;
      have      = 1'b0;
      for (int i = 1; i <= pnc_pkg::LAST_USABLE; i++) begin
        e       = model_palette[i];
        dr      = int'(e.red) - int'(req.colour.red);
        dg      = int'(e.green) - int'(req.colour.green);
        db      = int'(e.blue) - int'(req.colour.blue);
        sq_dist = dr * dr + dg * dg + db * db;
        if (!have || sq_dist < best_dist) begin
          have      = 1'b1;
          best_dist = sq_dist;
          ans.idx   = pnc_pkg::IDX_W'(i);
        end
      end
      ans.colour = model_palette[ans.idx];
      expected_colours.push_back(ans);
    end else if (req.op == pnc_pkg::OP_READ) begin
      ans.idx = req.idx;
      if (req.idx >= 1 && req.idx <= pnc_pkg::LAST_USABLE) ans.colour = model_palette[req.idx];
      else ans.colour = make_rgb(pnc_pkg::WHITE_LEVEL, pnc_pkg::WHITE_LEVEL,
                                 pnc_pkg::WHITE_LEVEL);
      expected_colours.push_back(ans);
    end
  endtask

  // Reports one field that differs from its expectation.
  function automatic bit field_differs(string name, int exp_val, int got_val);
    if (exp_val != got_val)
      $display("%0t: %s differs, expected %0d, got %0d", $time, name, exp_val, got_val);
    return exp_val != got_val;
  endfunction

  // Stimulus: directed cases, a full palette load, directed searches, then random traffic.
  initial begin
    pnc_pkg::rgb_t colour;
    int            pick;
    int            idx;
    counted_items  = 0;
    mismatch_count = 0;
    for (int i = 0; i < pnc_pkg::PALETTE_SIZE; i++) begin
      model_palette[i]  = '0;
      chosen_palette[i] = '0;
    end

    // Ignored items, index zero and the ends of the colour range.
    queue_request(OP_UNUSED, 255, make_rgb(255, 255, 255));
    queue_request(pnc_pkg::OP_WRITE, 0, make_rgb(8'h12, 8'h34, 8'h56));
    queue_request(pnc_pkg::OP_READ, 0, make_rgb(0, 0, 0));
    queue_request(pnc_pkg::OP_WRITE, 1, make_rgb(255, 255, 255));
    queue_request(pnc_pkg::OP_READ, 1, make_rgb(0, 0, 0));
    queue_request(pnc_pkg::OP_WRITE, pnc_pkg::LAST_USABLE, make_rgb(0, 0, 0));
    queue_request(pnc_pkg::OP_READ, pnc_pkg::LAST_USABLE, make_rgb(255, 255, 255));
    queue_request(pnc_pkg::OP_WRITE, 128, make_rgb(8'hAA, 8'h55, 8'hAA));
    queue_request(pnc_pkg::OP_READ, 128, make_rgb(8'h55, 8'hAA, 8'h55));
    queue_request(pnc_pkg::OP_WRITE, 1, make_rgb(8'h55, 8'hAA, 8'h55));
    queue_request(pnc_pkg::OP_READ, 1, make_rgb(0, 0, 0));
    queue_request(pnc_pkg::OP_WRITE, 0, make_rgb(255, 255, 255));
    queue_request(pnc_pkg::OP_READ, 0, make_rgb(0, 0, 0));
    queue_request(OP_UNUSED, 0, make_rgb(0, 0, 0));

    // Every searched entry has to hold a colour before the first search.
    for (int i = 1; i <= pnc_pkg::LAST_USABLE; i++)
      queue_request(pnc_pkg::OP_WRITE, i, random_rgb());

    // Searches at the corners of the colour cube and on exact entries.
    queue_request(pnc_pkg::OP_SEARCH, 0, make_rgb(0, 0, 0));
    queue_request(pnc_pkg::OP_SEARCH, 255, make_rgb(255, 255, 255));
    queue_request(pnc_pkg::OP_SEARCH, 0, chosen_palette[200]);
    // The start index is only returned when its own entry is nearest.
    queue_request(pnc_pkg::OP_WRITE, 7, make_rgb(8'h77, 8'h77, 8'h77));
    queue_request(pnc_pkg::OP_SEARCH, 7, make_rgb(8'h77, 8'h77, 8'h77));
    // A tie between two entries goes to the lower index.
    queue_request(pnc_pkg::OP_WRITE, 50, make_rgb(1, 2, 3));
    queue_request(pnc_pkg::OP_WRITE, 30, make_rgb(1, 2, 3));
    queue_request(pnc_pkg::OP_SEARCH, 0, make_rgb(1, 2, 3));
    // A tie that includes entry 1, the first one visited.
    queue_request(pnc_pkg::OP_WRITE, 9, chosen_palette[1]);
    queue_request(pnc_pkg::OP_SEARCH, 128, chosen_palette[1]);

    // Random traffic, mostly writes, searches and reads with some noise.
    while (counted_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        idx = ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(0, 255);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: colour = random_rgb();
          5, 6, 7:       colour = chosen_palette[$urandom_range(1, pnc_pkg::LAST_USABLE)];
          default:       colour = extreme_rgb();
        endcase
        queue_request(pnc_pkg::OP_WRITE, idx, colour);
      end else if (pick < 65) begin
        colour = chosen_palette[$urandom_range(1, pnc_pkg::LAST_USABLE)];
        case ($urandom_range(0, 9))
          0, 1, 2, 3: colour = random_rgb();
          4, 5, 6:    ;
          7, 8: begin
            colour.red   = nudge(colour.red);
            colour.green = nudge(colour.green);
            colour.blue  = nudge(colour.blue);
          end
          default:    colour = extreme_rgb();
        endcase
        queue_request(pnc_pkg::OP_SEARCH, $urandom_range(0, 255), colour);
      end else if (pick < 92) begin
        idx = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(0, 255);
        queue_request(pnc_pkg::OP_READ, idx, random_rgb());
      end else begin
        queue_request(OP_UNUSED, $urandom_range(0, 255), random_rgb());
      end
    end
    total_items = palette_requests.size();

    // Reset, then wait for every request to go in and every answer to come out.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (sent_items != total_items) @(posedge clk);
    while (expected_colours.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Request driver: offers queued requests with random gaps in between.
  always @(posedge clk) begin : request_driver
    logic busy;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      send_gap  = 0;
      send_calm = 1'b0;
    end else begin
      busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        predict_palette_answer(offered_req);
        sent_items++;
        busy     = 1'b0;
        send_gap = next_gap(send_calm);
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (palette_requests.size() != 0) begin
          offered_req = palette_requests.pop_front();
          busy        = 1'b1;
        end
      end
      in_tvalid <= busy;
      in_tdata  <= {offered_req.colour.blue, offered_req.colour.green,
                    offered_req.colour.red, offered_req.idx};
      in_tuser  <= offered_req.op;
    end
  end

  // Answer monitor: checks each result transaction against the oldest expectation.
  always @(posedge clk) begin : answer_monitor
    palette_answer_t exp_ans;
    bit              bad;
    if (!rst_n) begin
      out_tready   <= 1'b0;
      results_seen <= 0;
      recv_gap     = 0;
      recv_calm    = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (expected_colours.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, got %h",
                   $time, out_tdata);
          mismatch_count++;
        end else begin
          exp_ans = expected_colours.pop_front();
          bad = field_differs("best_index", exp_ans.idx, out_tdata[7:0]);
          bad |= field_differs("red_out", exp_ans.colour.red, out_tdata[15:8]);
          bad |= field_differs("green_out", exp_ans.colour.green, out_tdata[23:16]);
          bad |= field_differs("blue_out", exp_ans.colour.blue, out_tdata[31:24]);
          if (bad) mismatch_count++;
        end
        recv_gap = next_gap(recv_calm);
      end else if (recv_gap > 0) begin
        recv_gap--;
      end
      out_tready <= (recv_gap == 0) && !drain_hold;
    end
  end

  // One long output stall part way through, so that the block backs up its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      drain_hold  <= 1'b0;
      hold_done   = 1'b0;
      hold_cycles = 0;
    end else if (drain_hold) begin
      hold_cycles++;
      if (hold_cycles >= HOLD_CYCLES) begin
        drain_hold <= 1'b0;
        hold_done  = 1'b1;
      end
    end else if (!hold_done && results_seen == HOLD_AT) begin
      drain_hold  <= 1'b1;
      hold_cycles = 0;
    end
  end

  // Watchdog on the length of the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// ===== palette_nearest_color_top.f =====
hdl/pnc_pkg.sv
hdl/pnc_cell.sv
hdl/palette_nearest_color_top.sv
bench/tb_palette_nearest_color_top.sv
